// ===== rtl/core/acp_pkg.sv =====
// acp_pkg: shared constants, status codes and control structs for the
// affine cipher block; used by the interfaces and every rtl/core module
`timescale 1ns / 1ps

package acp_pkg;

    // alphabet defaults: printable ascii
    localparam int ALPHABET_SIZE_DEF = 95;
    localparam int FIRST_CODE_DEF    = 32;

    // fixed field widths
    localparam int KEY_W   = 7;
    localparam int CODE_W  = 8;
    localparam int OUT_W   = 7;
    localparam int STAT_W  = 2;
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_KEY   = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // register word index (paddr[2])
    localparam logic REG_MULT_KEY = 1'b0;
    localparam logic REG_ADD_KEY  = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic key_start;
        logic red_step;
        logic inv_start;
        logic inv_step;
        logic mul_load;
        logic mul_step;
        logic fin;
    } acp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic red_done;
        logic inv_done;
        logic mul_done;
    } acp_stat_t;

endpackage

// ===== rtl/core/acp_in_if.sv =====
// acp_in_if: request channel carrying mode and character byte
// depends on acp_pkg for field widths
`timescale 1ns / 1ps

interface acp_in_if import acp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [CODE_W-1:0] char_code;

    modport source (output valid, output mode, output char_code, input ready);
    modport sink   (input valid, input mode, input char_code, output ready);
endinterface

// ===== rtl/core/acp_out_if.sv =====
// acp_out_if: result channel carrying output code and status
// depends on acp_pkg for field widths
`timescale 1ns / 1ps

interface acp_out_if import acp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OUT_W-1:0]  out_code;
    logic [STAT_W-1:0] status;

    modport source (output valid, output out_code, output status, input ready);
    modport sink   (input valid, input out_code, input status, output ready);
endinterface

// ===== rtl/core/affine_cipher_printable_ascii_top.sv =====
// affine_cipher_printable_ascii_top: affine cipher over a contiguous code alphabet
// depends on acp_pkg, acp_in_if, acp_out_if, acp_regs, acp_ctrl, acp_dp
//
//   channel    dir   handshake              payload
//   data_req   in    valid / ready          mode, char_code
//   data_rsp   out   valid / ready          out_code, status
//   apb        in    psel, penable, pwrite  paddr, pwdata -> prdata, pready
//
// one request at a time, computed by the one-bit-per-cycle modular multiplier
// in the datapath; the first request after reset or after a key write first
// reduces the keys by repeated subtraction and then searches the inverse
// rst_n clears the sequencer, the key-cache valid flag and the result valid
// a stalled result stays in its register; the next request is still taken and
// waits for the register only at the very end of its computation
`timescale 1ns / 1ps

module affine_cipher_printable_ascii_top import acp_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
    parameter int FIRST_CODE    = FIRST_CODE_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // streams
    acp_in_if.sink             data_req,
    acp_out_if.source          data_rsp
);

    logic [KEY_W-1:0] mult_key;
    logic [KEY_W-1:0] add_key;
    logic             key_wr;
    acp_cmd_t         cmd;
    acp_stat_t        stat;

    // zero wait state port
    assign pready = 1'b1;

    // key registers and write strobe
    acp_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .mult_key (mult_key),
        .add_key  (add_key),
        .key_wr   (key_wr)
    );

    // sequencer: handshakes, key cache validity, step control
    acp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (data_req.valid),
        .in_ready  (data_req.ready),
        .out_valid (data_rsp.valid),
        .out_ready (data_rsp.ready),
        .key_wr    (key_wr),
        .stat      (stat),
        .cmd       (cmd)
    );

    // arithmetic and result register
    acp_dp #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .FIRST_CODE    (FIRST_CODE)
    ) u_dp (
        .clk       (clk),
        .cmd       (cmd),
        .stat      (stat),
        .mult_key  (mult_key),
        .add_key   (add_key),
        .mode      (data_req.mode),
        .char_code (data_req.char_code),
        .out_code  (data_rsp.out_code),
        .status    (data_rsp.status)
    );

endmodule

// ===== rtl/core/acp_regs.sv =====
// acp_regs: apb register file holding mult_key and add_key
// depends on acp_pkg; flags every write so cached key data is rebuilt
`timescale 1ns / 1ps

module acp_regs import acp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic [KEY_W-1:0]   mult_key,
    output logic [KEY_W-1:0]   add_key,
    output logic               key_wr
);

    logic [KEY_W-1:0] mult_key_reg, mult_key_next;
    logic [KEY_W-1:0] add_key_reg, add_key_next;
    logic             wr_en;
    logic             idx;

    assign idx   = paddr[PADDR_W-1];
    assign wr_en = psel & penable & pwrite;

    always_comb
    begin
        mult_key_next = mult_key_reg;
        add_key_next  = add_key_reg;
        if (wr_en)
        begin
            if (idx == REG_MULT_KEY)
            begin
                mult_key_next = pwdata[KEY_W-1:0];
            end
            else
            begin
                add_key_next = pwdata[KEY_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_key_reg <= KEY_W'(1);
            add_key_reg  <= '0;
        end
        else
        begin
            mult_key_reg <= mult_key_next;
            add_key_reg  <= add_key_next;
        end
    end

    // read mux, zero extended
    assign prdata   = (idx == REG_MULT_KEY) ? PDATA_W'(mult_key_reg) : PDATA_W'(add_key_reg);
    assign mult_key = mult_key_reg;
    assign add_key  = add_key_reg;
    assign key_wr   = wr_en;

endmodule

// ===== rtl/core/acp_ctrl.sv =====
// acp_ctrl: sequencer for key preparation, serial multiply and result hand-off
// depends on acp_pkg command and status structs
`timescale 1ns / 1ps

module acp_ctrl import acp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  logic      key_wr,
    input  acp_stat_t stat,
    output acp_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RED  = 6'b000010,
        S_INV  = 6'b000100,
        S_LOAD = 6'b001000,
        S_MUL  = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   key_valid_reg, key_valid_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    // result register can take a new value when empty or being drained
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        key_valid_next = key_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (key_valid_reg)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        cmd.key_start = 1'b1;
                        state_next    = S_RED;
                    end
                end
            end
            S_RED:
            begin
                if (stat.red_done)
                begin
                    cmd.inv_start = 1'b1;
                    state_next    = S_INV;
                end
                else
                begin
                    cmd.red_step = 1'b1;
                end
            end
            S_INV:
            begin
                cmd.inv_step = 1'b1;
                if (stat.inv_done)
                begin
                    key_valid_next = 1'b1;
                    state_next     = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // any key write drops the cached reduced keys and inverse
        if (key_wr)
        begin
            key_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.fin)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_valid_reg <= key_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/acp_dp.sv =====
// acp_dp: key reduction, inverse search, bit-serial modular multiply, result register
// depends on acp_pkg; driven by acp_ctrl commands
`timescale 1ns / 1ps

module acp_dp import acp_pkg::*;
#(
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
    parameter int FIRST_CODE    = FIRST_CODE_DEF
)
(
    input  logic              clk,
    input  acp_cmd_t          cmd,
    output acp_stat_t         stat,
    input  logic [KEY_W-1:0]  mult_key,
    input  logic [KEY_W-1:0]  add_key,
    input  logic              mode,
    input  logic [CODE_W-1:0] char_code,
    output logic [OUT_W-1:0]  out_code,
    output logic [STAT_W-1:0] status
);

    localparam int AW = $clog2(ALPHABET_SIZE);
    localparam int CW = $clog2(AW + 1);
    localparam int WW = 10;
    localparam logic [WW-1:0] M_W    = WW'(ALPHABET_SIZE);
    localparam logic [WW-1:0] M2_W   = WW'(2 * ALPHABET_SIZE);
    localparam logic [WW-1:0] FC_W   = WW'(FIRST_CODE);
    localparam logic [WW-1:0] FE_W   = WW'(FIRST_CODE + ALPHABET_SIZE);
    localparam logic [AW-1:0] LAST_K = AW'(ALPHABET_SIZE - 1);
    localparam logic [CW-1:0] LAST_C = CW'(AW - 1);

    // item
    logic              mode_reg, mode_next;
    logic [AW-1:0]     x_reg, x_next;
    logic              range_bad_reg, range_bad_next;
    // key cache
    logic [KEY_W-1:0]  ared_reg, ared_next;
    logic [KEY_W-1:0]  bred_reg, bred_next;
    logic [AW-1:0]     inv_reg, inv_next;
    logic              key_ok_reg, key_ok_next;
    logic [AW-1:0]     k_reg, k_next;
    logic [AW-1:0]     acc_reg, acc_next;
    // multiplier
    logic [AW-1:0]     macc_reg, macc_next;
    logic [AW-1:0]     mcand_reg, mcand_next;
    logic [AW-1:0]     mplier_reg, mplier_next;
    logic [AW-1:0]     addend_reg, addend_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    // result
    logic [OUT_W-1:0]  code_reg, code_next;
    logic [STAT_W-1:0] stat_reg, stat_next;

    logic [WW-1:0] ared_w, bred_w, code_w, x_w;
    logic [AW-1:0] a_k, b_k;
    logic [WW-1:0] acc_sum, acc_mod;
    logic          found, last_k;
    logic [WW-1:0] d_w;
    logic [WW-1:0] mt, mt_mod;
    logic [WW-1:0] ysum, y_w, res_w;

    assign ared_w = WW'(ared_reg);
    assign bred_w = WW'(bred_reg);
    assign a_k    = ared_w[AW-1:0];
    assign b_k    = bred_w[AW-1:0];

    assign code_w = WW'(char_code);
    assign x_w    = code_w - FC_W;

    // next multiple of a in the inverse search
    assign acc_sum = WW'(acc_reg) + WW'(a_k);
    assign acc_mod = (acc_sum >= M_W) ? (acc_sum - M_W) : acc_sum;
    assign found   = (acc_reg == AW'(1));
    assign last_k  = (k_reg == LAST_K);

    // decrypt offset (x - b) mod m
    assign d_w = (WW'(x_reg) >= WW'(b_k)) ? (WW'(x_reg) - WW'(b_k))
                                          : (WW'(x_reg) + M_W - WW'(b_k));

    // horner step, msb first: 2*acc + bit*mcand stays below 3m
    assign mt     = (WW'(macc_reg) << 1) + (mplier_reg[AW-1] ? WW'(mcand_reg) : '0);
    assign mt_mod = (mt >= M2_W) ? (mt - M2_W) : ((mt >= M_W) ? (mt - M_W) : mt);

    assign ysum  = WW'(macc_reg) + WW'(addend_reg);
    assign y_w   = (ysum >= M_W) ? (ysum - M_W) : ysum;
    assign res_w = y_w + FC_W;

    always_comb
    begin
        mode_next      = mode_reg;
        x_next         = x_reg;
        range_bad_next = range_bad_reg;
        ared_next      = ared_reg;
        bred_next      = bred_reg;
        inv_next       = inv_reg;
        key_ok_next    = key_ok_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        macc_next      = macc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        addend_next    = addend_reg;
        cnt_next       = cnt_reg;
        code_next      = code_reg;
        stat_next      = stat_reg;

        if (cmd.load_item)
        begin
            mode_next      = mode;
            x_next         = x_w[AW-1:0];
            range_bad_next = (code_w < FC_W) || (code_w >= FE_W);
        end
        if (cmd.key_start)
        begin
            ared_next = mult_key;
            bred_next = add_key;
        end
        if (cmd.red_step)
        begin
            if (ared_w >= M_W)
            begin
                ared_next = ared_reg - KEY_W'(ALPHABET_SIZE);
            end
            if (bred_w >= M_W)
            begin
                bred_next = bred_reg - KEY_W'(ALPHABET_SIZE);
            end
        end
        if (cmd.inv_start)
        begin
            k_next   = AW'(1);
            acc_next = a_k;
        end
        if (cmd.inv_step)
        begin
            priority if (found)
            begin
                inv_next    = k_reg;
                key_ok_next = 1'b1;
            end
            else if (last_k)
            begin
                key_ok_next = 1'b0;
            end
            else
            begin
                k_next   = k_reg + AW'(1);
                acc_next = acc_mod[AW-1:0];
            end
        end
        if (cmd.mul_load)
        begin
            macc_next   = '0;
            cnt_next    = '0;
            mplier_next = mode_reg ? d_w[AW-1:0] : x_reg;
            mcand_next  = mode_reg ? inv_reg : a_k;
            addend_next = mode_reg ? '0 : b_k;
        end
        if (cmd.mul_step)
        begin
            macc_next   = mt_mod[AW-1:0];
            mplier_next = mplier_reg << 1;
            cnt_next    = cnt_reg + CW'(1);
        end
        if (cmd.fin)
        begin
            priority if (!key_ok_reg)
            begin
                code_next = '0;
                stat_next = ST_KEY;
            end
            else if (range_bad_reg)
            begin
                code_next = '0;
                stat_next = ST_RANGE;
            end
            else
            begin
                code_next = res_w[OUT_W-1:0];
                stat_next = ST_OK;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        x_reg         <= x_next;
        range_bad_reg <= range_bad_next;
        ared_reg      <= ared_next;
        bred_reg      <= bred_next;
        inv_reg       <= inv_next;
        key_ok_reg    <= key_ok_next;
        k_reg         <= k_next;
        acc_reg       <= acc_next;
        macc_reg      <= macc_next;
        mcand_reg     <= mcand_next;
        mplier_reg    <= mplier_next;
        addend_reg    <= addend_next;
        cnt_reg       <= cnt_next;
        code_reg      <= code_next;
        stat_reg      <= stat_next;
    end

    assign stat.red_done = (ared_w < M_W) && (bred_w < M_W);
    assign stat.inv_done = found || last_k;
    assign stat.mul_done = (cnt_reg == LAST_C);

    assign out_code = code_reg;
    assign status   = stat_reg;

endmodule
